### rtl/ycc_pkg.sv
`timescale 1ns / 1ps

package ycc_pkg;

    // field widths
    localparam int LUMA_W   = 16;
    localparam int RAW_W    = 16;
    localparam int CHROMA_W = 18;
    localparam int HUE_W    = 11;
    localparam int COEFF_W  = 16;
    localparam int CHAN_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // lane datapath widths
    localparam int PROD_W = 32;
    localparam int VAL_W  = 21;
    localparam int MUL_W  = VAL_W + COEFF_W + 1;

    // default depth of the pair queue in the merge stage (power of two)
    localparam int PAIR_DEPTH_DEF = 4;

    // chroma bias and formula offset
    localparam int CHROMA_BIAS = 16384;
    localparam int FORM_OFFSET_BIAS = 512;
    localparam int MAT_SHIFT   = 12;
    localparam int COEFF_SHIFT = 8;

    // formula select codes (value 3 behaves as plain)
    localparam logic [1:0] FORM_OFFSET = 2'd0;
    localparam logic [1:0] FORM_MATRIX = 2'd1;
    localparam logic [1:0] FORM_PLAIN  = 2'd2;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORMULA = 3'd0,
        CFG_HUE     = 3'd1,
        CFG_COEFF_R = 3'd2,
        CFG_COEFF_G = 3'd3,
        CFG_COEFF_B = 3'd4
    } t_cfg_idx;

    // reset values of the config registers
    localparam logic [1:0]         RST_FORMULA = FORM_PLAIN;
    localparam logic [COEFF_W-1:0] RST_COEFF   = 16'd1024;

    // channel order in the lanes
    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;
    localparam int NUM_CH = 3;

    // matrix coefficients per channel, for Cb and Cr
    localparam logic signed [15:0] K_CB_MAT [NUM_CH] = '{16'sd50, -16'sd5640, 16'sd29040};
    localparam logic signed [15:0] K_CR_MAT [NUM_CH] = '{16'sd22929, -16'sd11751, -16'sd101};
    // coefficients of the plain and offset formulas (only green uses the shift)
    localparam logic signed [15:0] K_CB_PLN [NUM_CH] = '{16'sd0, -16'sd778, 16'sd0};
    localparam logic signed [15:0] K_CR_PLN [NUM_CH] = '{16'sd0, -16'sd2048, 16'sd0};

    // one pixel going into a lane
    typedef struct packed {
        logic [LUMA_W-1:0]          y;
        logic signed [CHROMA_W-1:0] cb;
        logic signed [CHROMA_W-1:0] cr;
        logic                       row_end;
        logic                       last_of_run;
    } t_pix_in;

    typedef struct packed {
        t_pix_in p0;
        t_pix_in p1;
    } t_pair_in;

    // one finished pixel
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
        logic              last_of_run;
    } t_pix_out;

    typedef struct packed {
        t_pix_out p0;
        t_pix_out p1;
    } t_pair_out;

    // per-pixel flags carried along the lane
    typedef struct packed {
        logic row_end;
        logic last_of_run;
    } t_pix_tag;

endpackage

### rtl/ycc_lane.sv
`timescale 1ns / 1ps

module ycc_lane import ycc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_pix_in            i_pix,
    input  logic [1:0]         i_formula,
    input  logic [COEFF_W-1:0] i_coeff_red,
    input  logic [COEFF_W-1:0] i_coeff_green,
    input  logic [COEFF_W-1:0] i_coeff_blue,
    output logic               o_valid,
    output t_pix_out           o_pix
);

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4;
    // stage tags
    t_pix_tag r_t1, r_t2, r_t3, r_t4;

    // stage 1: constant products
    logic [LUMA_W-1:0]          r_s1_y;
    logic signed [CHROMA_W-1:0] r_s1_cb, r_s1_cr;
    logic                       r_s1_mat, r_s1_off;
    logic signed [PROD_W-1:0]   r_s1_pb [NUM_CH];
    logic signed [PROD_W-1:0]   r_s1_pr [NUM_CH];
    logic signed [PROD_W-1:0]   n_s1_pb [NUM_CH];
    logic signed [PROD_W-1:0]   n_s1_pr [NUM_CH];
    logic                       w_mat;

    // stage 2: channel value before scaling
    logic signed [VAL_W-1:0] r_s2_v [NUM_CH];
    logic signed [VAL_W-1:0] n_s2_v [NUM_CH];

    // stage 3: scaled product
    logic signed [MUL_W-1:0] r_s3_m [NUM_CH];
    logic signed [MUL_W-1:0] n_s3_m [NUM_CH];
    logic [COEFF_W-1:0]      w_coeff [NUM_CH];

    // stage 4: clamped channel
    logic [CHAN_W-1:0] r_s4_c [NUM_CH];
    logic [CHAN_W-1:0] n_s4_c [NUM_CH];

    assign w_mat = (i_formula == FORM_MATRIX);
    assign w_coeff[CH_R] = i_coeff_red;
    assign w_coeff[CH_G] = i_coeff_green;
    assign w_coeff[CH_B] = i_coeff_blue;

    // products of chroma with the formula constants
    always_comb begin
        logic signed [PROD_W+1:0] pb, pr;
        for (int c = 0; c < NUM_CH; c++) begin
            pb = (PROD_W+2)'(i_pix.cb) * (PROD_W+2)'(w_mat ? K_CB_MAT[c] : K_CB_PLN[c]);
            pr = (PROD_W+2)'(i_pix.cr) * (PROD_W+2)'(w_mat ? K_CR_MAT[c] : K_CR_PLN[c]);
            n_s1_pb[c] = pb[PROD_W-1:0];
            n_s1_pr[c] = pr[PROD_W-1:0];
        end
    end

    // sum, floor shift and luma add
    always_comb begin
        logic signed [PROD_W:0]  s;
        logic signed [VAL_W-1:0] sh, y, off, direct;
        y   = signed'(VAL_W'(r_s1_y));
        off = r_s1_off ? (VAL_W'(0) - VAL_W'(FORM_OFFSET_BIAS)) : VAL_W'(0);
        for (int c = 0; c < NUM_CH; c++) begin
            s  = (PROD_W+1)'(r_s1_pb[c]) + (PROD_W+1)'(r_s1_pr[c]);
            sh = VAL_W'(s >>> MAT_SHIFT);
            direct = (c == CH_R) ? VAL_W'(r_s1_cr) : VAL_W'(r_s1_cb);
            if (r_s1_mat || c == CH_G) begin
                n_s2_v[c] = y + sh + off;
            end else begin
                n_s2_v[c] = y + direct + off;
            end
        end
    end

    // per-channel coefficient
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_s3_m[c] = MUL_W'(signed'({1'b0, w_coeff[c]})) * MUL_W'(r_s2_v[c]);
        end
    end

    // shift by eight and clamp
    always_comb begin
        logic signed [MUL_W-COEFF_SHIFT-1:0] t;
        for (int c = 0; c < NUM_CH; c++) begin
            t = (MUL_W-COEFF_SHIFT)'(r_s3_m[c] >>> COEFF_SHIFT);
            if (t < 0) begin
                n_s4_c[c] = '0;
            end else if (t > (MUL_W-COEFF_SHIFT)'(2**CHAN_W - 1)) begin
                n_s4_c[c] = '1;
            end else begin
                n_s4_c[c] = t[CHAN_W-1:0];
            end
        end
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_s1_y   <= i_pix.y;
        r_s1_cb  <= i_pix.cb;
        r_s1_cr  <= i_pix.cr;
        r_s1_mat <= w_mat;
        r_s1_off <= (i_formula == FORM_OFFSET);
        r_t1     <= '{row_end: i_pix.row_end, last_of_run: i_pix.last_of_run};
        r_t2     <= r_t1;
        r_t3     <= r_t2;
        r_t4     <= r_t3;
        r_s1_pb  <= n_s1_pb;
        r_s1_pr  <= n_s1_pr;
        r_s2_v   <= n_s2_v;
        r_s3_m   <= n_s3_m;
        r_s4_c   <= n_s4_c;
    end

    assign o_valid           = r_v4;
    assign o_pix.red         = r_s4_c[CH_R];
    assign o_pix.green       = r_s4_c[CH_G];
    assign o_pix.blue        = r_s4_c[CH_B];
    assign o_pix.row_end     = r_t4.row_end;
    assign o_pix.last_of_run = r_t4.last_of_run;

endmodule

### rtl/ycc_merge.sv
`timescale 1ns / 1ps

module ycc_merge import ycc_pkg::*; #(
    parameter int PAIR_DEPTH = PAIR_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_pair_out i_pair,
    input  logic      i_ready,
    output logic      o_valid,
    output t_pix_out  o_pix,
    output logic      o_pop
);

    localparam int PTR_W = $clog2(PAIR_DEPTH);
    localparam int CNT_W = $clog2(PAIR_DEPTH + 1);

    t_pair_out        r_mem [PAIR_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             r_half;
    t_pair_out        w_head;
    logic             w_beat;

    assign w_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_pix   = r_half ? w_head.p1 : w_head.p0;
    assign w_beat  = o_valid && i_ready;
    // a pair leaves once its odd pixel is taken
    assign o_pop   = w_beat && r_half;

    // pair storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_pair;
        end
    end

    // pointers, fill count and pixel select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_half   <= 1'b0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (o_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_beat) begin
                r_half <= !r_half;
            end
            if (i_wr && !o_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_wr && o_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/ycbcr422_interp_to_rgb_core.sv
`timescale 1ns / 1ps

// channel | valid      | ready        | payload
// --------+------------+--------------+--------------------------------------------
// unit in | i_in_valid | o_in_ready   | i_luma_first/second, i_chroma_blue/red,
//         |            |              | i_last_in_row
// pixel   | o_out_valid| i_out_ready  | o_red, o_green, o_blue, o_row_end,
//         |            |              | o_last_of_run
// config  | i_cfg_valid| o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a unit issues no pair, one pair (two pixels) or two pairs (four pixels):
// pairs go one per cycle, while the queue has room, into the two lanes sharing one issue port.
// pixels leave one per cycle while i_out_ready is high; pairs enter the queue from the lanes.
// reset is synchronous; it clears the held unit, the lanes and the pair queue.
// a stalled output fills the pair queue; issue waits once PAIR_DEPTH pairs are
// in flight, and then input stalls. config is taken every cycle.

module ycbcr422_interp_to_rgb_core import ycc_pkg::*; #(
    parameter int PAIR_DEPTH = PAIR_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [LUMA_W-1:0]     i_luma_first,
    input  logic [LUMA_W-1:0]     i_luma_second,
    input  logic [RAW_W-1:0]      i_chroma_blue,
    input  logic [RAW_W-1:0]      i_chroma_red,
    input  logic                  i_last_in_row,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_W-1:0]     o_red,
    output logic [CHAN_W-1:0]     o_green,
    output logic [CHAN_W-1:0]     o_blue,
    output logic                  o_row_end,
    output logic                  o_last_of_run,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int INF_W = $clog2(PAIR_DEPTH + 1);

    // config registers
    logic [1:0]              r_formula;
    logic signed [HUE_W-1:0] r_hue;
    logic [COEFF_W-1:0]      r_coeff_r, r_coeff_g, r_coeff_b;

    // held unit
    logic                       r_held_vld;
    logic [LUMA_W-1:0]          r_held_y0, r_held_y1;
    logic signed [CHROMA_W-1:0] r_held_cb, r_held_cr;

    // pending pairs of the current unit
    logic     r_pend_a, r_pend_b;
    t_pair_in r_pair_a, r_pair_b;
    t_pair_in n_pair_a, n_pair_b;

    logic [INF_W-1:0] r_inflight;

    logic                       w_accept, w_credit, w_issue_a, w_issue_b, w_issue;
    logic signed [CHROMA_W-1:0] w_cb, w_cr, w_avg_cb, w_avg_cr;
    t_pair_in                   w_lane_in;
    logic                       w_lane_vld0, w_lane_vld1;
    t_pair_out                  w_lane_out;
    logic                       w_pop;
    t_pix_out                   w_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !(r_pend_a || r_pend_b);
    assign w_accept    = i_in_valid && o_in_ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_formula <= RST_FORMULA;
            r_hue     <= '0;
            r_coeff_r <= RST_COEFF;
            r_coeff_g <= RST_COEFF;
            r_coeff_b <= RST_COEFF;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FORMULA: r_formula <= i_cfg_data[1:0];
                CFG_HUE:     r_hue     <= signed'(i_cfg_data[HUE_W-1:0]);
                CFG_COEFF_R: r_coeff_r <= i_cfg_data;
                CFG_COEFF_G: r_coeff_g <= i_cfg_data;
                CFG_COEFF_B: r_coeff_b <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // chroma centering, hue offset and averaging with the held unit
    always_comb begin
        logic signed [CHROMA_W:0] sb, sr;
        w_cb = signed'(CHROMA_W'(i_chroma_blue)) - CHROMA_W'(CHROMA_BIAS) + CHROMA_W'(r_hue);
        w_cr = signed'(CHROMA_W'(i_chroma_red)) - CHROMA_W'(CHROMA_BIAS) + CHROMA_W'(r_hue);
        sb   = (CHROMA_W+1)'(r_held_cb) + (CHROMA_W+1)'(w_cb);
        sr   = (CHROMA_W+1)'(r_held_cr) + (CHROMA_W+1)'(w_cr);
        w_avg_cb = CHROMA_W'(sb >>> 1);
        w_avg_cr = CHROMA_W'(sr >>> 1);
    end

    // pairs built from the held unit and from a row-final unit
    always_comb begin
        n_pair_a.p0 = '{y: r_held_y0, cb: r_held_cb, cr: r_held_cr,
                        row_end: 1'b0, last_of_run: 1'b0};
        n_pair_a.p1 = '{y: r_held_y1, cb: w_avg_cb, cr: w_avg_cr,
                        row_end: 1'b0, last_of_run: !i_last_in_row};
        n_pair_b.p0 = '{y: i_luma_first, cb: w_cb, cr: w_cr,
                        row_end: 1'b0, last_of_run: 1'b0};
        n_pair_b.p1 = '{y: i_luma_second, cb: w_cb, cr: w_cr,
                        row_end: 1'b1, last_of_run: 1'b1};
    end

    // issue one pair a cycle while the queue has room
    assign w_credit  = (r_inflight < INF_W'(PAIR_DEPTH));
    assign w_issue_a = r_pend_a && w_credit;
    assign w_issue_b = !r_pend_a && r_pend_b && w_credit;
    assign w_issue   = w_issue_a || w_issue_b;
    assign w_lane_in = w_issue_a ? r_pair_a : r_pair_b;

    // unit sequencing and held state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vld <= 1'b0;
            r_pend_a   <= 1'b0;
            r_pend_b   <= 1'b0;
        end else if (w_accept) begin
            r_pend_a   <= r_held_vld;
            r_pend_b   <= i_last_in_row;
            r_held_vld <= !i_last_in_row;
        end else begin
            if (w_issue_a) begin
                r_pend_a <= 1'b0;
            end
            if (w_issue_b) begin
                r_pend_b <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pair_a <= n_pair_a;
            r_pair_b <= n_pair_b;
            if (!i_last_in_row) begin
                r_held_y0 <= i_luma_first;
                r_held_y1 <= i_luma_second;
                r_held_cb <= w_cb;
                r_held_cr <= w_cr;
            end
        end
    end

    // pairs issued and not yet drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_issue && !w_pop) begin
            r_inflight <= r_inflight + INF_W'(1);
        end else if (!w_issue && w_pop) begin
            r_inflight <= r_inflight - INF_W'(1);
        end
    end

    // even and odd pixel lanes
    ycc_lane u_lane0 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_issue),
        .i_pix         (w_lane_in.p0),
        .i_formula     (r_formula),
        .i_coeff_red   (r_coeff_r),
        .i_coeff_green (r_coeff_g),
        .i_coeff_blue  (r_coeff_b),
        .o_valid       (w_lane_vld0),
        .o_pix         (w_lane_out.p0)
    );

    ycc_lane u_lane1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_issue),
        .i_pix         (w_lane_in.p1),
        .i_formula     (r_formula),
        .i_coeff_red   (r_coeff_r),
        .i_coeff_green (r_coeff_g),
        .i_coeff_blue  (r_coeff_b),
        .o_valid       (w_lane_vld1),
        .o_pix         (w_lane_out.p1)
    );

    // pair queue and pixel serializer
    ycc_merge #(
        .PAIR_DEPTH (PAIR_DEPTH)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_lane_vld0 && w_lane_vld1),
        .i_pair  (w_lane_out),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_pix   (w_out),
        .o_pop   (w_pop)
    );

    assign o_red         = w_out.red;
    assign o_green       = w_out.green;
    assign o_blue        = w_out.blue;
    assign o_row_end     = w_out.row_end;
    assign o_last_of_run = w_out.last_of_run;

endmodule

### rtl/ycc_checker.sv
`timescale 1ns / 1ps

module ycc_checker import ycc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_last_in_row,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [CHAN_W-1:0]     o_red,
    input logic [CHAN_W-1:0]     o_green,
    input logic [CHAN_W-1:0]     o_blue,
    input logic                  o_row_end,
    input logic                  o_last_of_run,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    // a waiting pixel holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red)
            && $stable(o_green) && $stable(o_blue) && $stable(o_row_end)
            && $stable(o_last_of_run))
        else $error("output pixel changed while stalled");

    // the end of a row always closes the run of its unit
    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_end |-> o_last_of_run)
        else $error("row end without last of run");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a row-final unit always has pixels to issue, so input pauses
    a_last_pauses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_in_row |=> !o_in_ready)
        else $error("input ready right after a row-final unit");

    // config port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config port stalled");

endmodule

bind ycbcr422_interp_to_rgb_core ycc_checker u_ycc_checker (.*);
